// ----- rtl/unsigned64_integer_alu_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the unsigned integer ALU
// Shared property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef UNSIGNED64_INTEGER_ALU_TOP_MACROS_SVH
`define UNSIGNED64_INTEGER_ALU_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define UIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define UIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/uia_pkg.sv -----
// ---------------------------------------------------------------------------
// Unsigned integer ALU package
// Opcodes and shared types.
// ---------------------------------------------------------------------------
package uia_pkg;

    localparam int DataWidthDef = 64;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_EQ     = 4'd2,
        OP_LT     = 4'd3,
        OP_LE     = 4'd4,
        OP_MOD    = 4'd5,
        OP_MUL    = 4'd6,
        OP_POW    = 4'd7,
        OP_DIV    = 4'd8,
        OP_DIVMOD = 4'd9,
        OP_CMP    = 4'd10,
        OP_NEG    = 4'd11,
        OP_SQRT   = 4'd12,
        OP_ISZERO = 4'd13,
        OP_RSV14  = 4'd14,
        OP_RSV15  = 4'd15
    } t_op;

    localparam logic [1:0] SignGt = 2'b01;
    localparam logic [1:0] SignLt = 2'b11;
    localparam logic [1:0] SignEq = 2'b00;

endpackage

// ----- rtl/uia_addsub.sv -----
// ---------------------------------------------------------------------------
// Shared adder/subtractor
// One wide add with carry out, used by every iterative step.
// ---------------------------------------------------------------------------
module uia_addsub #(
    parameter int W = uia_pkg::DataWidthDef
) (
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);
    logic [W:0] w_full;
    assign w_full  = {1'b0, i_x} + {1'b0, (i_sub ? ~i_y : i_y)} + {{W{1'b0}}, i_sub};
    assign o_sum   = w_full[W-1:0];
    assign o_carry = w_full[W];
endmodule

// ----- rtl/unsigned64_integer_alu_top.sv -----
// ---------------------------------------------------------------------------
// Unsigned integer ALU, top level
// Iterative ALU built around one shared adder under a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries i_func, i_operand_a, i_operand_b.
//   Output channel o_valid/i_ready carries the five result fields.
//   A request is taken only while the block is idle; o_ready stays low
//   from acceptance until the result is taken.
// Sequencing after accept:
//   add, sub, neg, compares, iszero: the S_CMP state registers the adder result.
//   mul, div/mod/divmod, sqrt: one bit per adder pass, then S_DONE.
//   pow: each exponent bit costs a shift-add multiply,
//   each bit but the last a squaring too, and the loop stops after the
//   highest set exponent bit.
// All multi-cycle work goes through the single W-bit adder.
// Divide by zero skips the loop and returns an all-ones quotient.
// Reset clears the sequencer and the output valid; payload is not reset.
// A stalled receiver holds the result in the output registers and the
// block accepts no new request until it is taken.
// ---------------------------------------------------------------------------
module unsigned64_integer_alu_top #(
    parameter int DATA_WIDTH = uia_pkg::DataWidthDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_func,
    input  logic [63:0]           i_operand_a,
    input  logic [63:0]           i_operand_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_value_out,
    output logic [63:0]           o_remainder_out,
    output logic                  o_truth_flag,
    output logic signed [1:0]     o_order_sign,
    output logic                  o_divide_by_zero
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    // Highest even bit position below W: first trial bit of the root.
    localparam int SqrtTop = ((W - 1) / 2) * 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CMP, S_MUL, S_DIV, S_SQRT, S_PSQ, S_PMUL, S_DONE
    } t_state;

    t_state       r_state;
    uia_pkg::t_op r_op;
    logic [W-1:0] r_a, r_b, r_acc, r_x, r_y, r_base, r_exp, r_res, r_bit;
    logic [CW-1:0] r_cnt;
    logic         r_dz;
    logic         r_valid;
    logic [63:0]  r_val, r_rem;
    logic         r_truth;
    logic [1:0]   r_sign;

    // Shared adder operands.
    logic [W-1:0] w_x, w_y, w_sum;
    logic         w_sub, w_carry;

    uia_addsub #(.W(W)) u_add (
        .i_x(w_x), .i_y(w_y), .i_sub(w_sub), .o_sum(w_sum), .o_carry(w_carry)
    );

    // Partial remainder shifted with next dividend bit.
    logic [W:0]   w_prem;
    logic         w_dfit;
    logic [W-1:0] w_rb;   // sqrt trial: res + bit
    assign w_prem = {r_acc, r_a[W-1]};
    assign w_rb   = r_res | r_bit;

    always_comb begin
        w_x = r_a; w_y = r_b; w_sub = 1'b1;
        unique case (r_state)
            S_MUL, S_PSQ, S_PMUL: begin
                w_x = r_acc; w_y = r_y; w_sub = 1'b0;
            end
            S_DIV: begin
                w_x = w_prem[W-1:0]; w_y = r_b; w_sub = 1'b1;
            end
            S_SQRT: begin
                w_x = r_a; w_y = w_rb; w_sub = 1'b1;
            end
            default: begin
                w_sub = (r_op != uia_pkg::OP_ADD);
                w_x   = (r_op == uia_pkg::OP_NEG) ? '0 : r_a;
                w_y   = (r_op == uia_pkg::OP_NEG) ? r_a : r_b;
            end
        endcase
    end
    // Remainder fits when shifted value >= divisor (borrow clear or top bit set).
    assign w_dfit = w_prem[W] | w_carry;

    function automatic logic [63:0] ext(input logic [W-1:0] v);
        ext = 64'(v);
    endfunction

    assign o_ready          = (r_state == S_IDLE) && !r_valid;
    assign o_valid          = r_valid;
    assign o_value_out      = r_val;
    assign o_remainder_out  = r_rem;
    assign o_truth_flag     = r_truth;
    assign o_order_sign     = r_sign;
    assign o_divide_by_zero = r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op  <= uia_pkg::t_op'(i_func);
                        r_a   <= i_operand_a[W-1:0];
                        r_b   <= i_operand_b[W-1:0];
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_val <= '0; r_rem <= '0; r_truth <= 1'b0;
                        r_sign <= uia_pkg::SignEq;
                        r_dz <= (i_operand_b[W-1:0] == '0) &&
                                ((uia_pkg::t_op'(i_func) == uia_pkg::OP_DIV) ||
                                 (uia_pkg::t_op'(i_func) == uia_pkg::OP_DIVMOD) ||
                                 (uia_pkg::t_op'(i_func) == uia_pkg::OP_MOD));
                        unique case (uia_pkg::t_op'(i_func))
                            uia_pkg::OP_MUL: begin
                                r_x <= i_operand_a[W-1:0];  // multiplier bits
                                r_y <= i_operand_b[W-1:0];  // shifted multiplicand
                                r_state <= S_MUL;
                            end
                            uia_pkg::OP_DIV, uia_pkg::OP_DIVMOD, uia_pkg::OP_MOD: begin
                                if (i_operand_b[W-1:0] == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            uia_pkg::OP_SQRT: begin
                                r_res <= '0;
                                r_bit <= {{(W-1){1'b0}}, 1'b1} << SqrtTop;
                                r_state <= S_SQRT;
                            end
                            uia_pkg::OP_POW: begin
                                r_base <= i_operand_a[W-1:0];
                                r_exp  <= i_operand_b[W-1:0];
                                r_res  <= {{(W-1){1'b0}}, 1'b1};
                                r_state <= S_PMUL;
                                r_x <= i_operand_b[0] ? i_operand_a[W-1:0] : '0;
                                r_y <= {{(W-1){1'b0}}, 1'b1};
                            end
                            default: r_state <= S_CMP;
                        endcase
                    end
                end
                S_CMP: begin
                    // Sum of a + ~b + 1: carry means a >= b.
                    unique case (r_op)
                        uia_pkg::OP_ADD, uia_pkg::OP_SUB, uia_pkg::OP_NEG:
                            r_val <= ext(w_sum);
                        uia_pkg::OP_EQ:  r_truth <= (r_a == r_b);
                        uia_pkg::OP_LT:  r_truth <= !w_carry;
                        uia_pkg::OP_LE:  r_truth <= !w_carry || (r_a == r_b);
                        uia_pkg::OP_CMP:
                            r_sign <= !w_carry ? uia_pkg::SignLt :
                                      (r_a == r_b) ? uia_pkg::SignEq : uia_pkg::SignGt;
                        uia_pkg::OP_ISZERO: r_truth <= (r_a == '0);
                        default: ;
                    endcase
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MUL: begin
                    // Add shifted multiplicand when multiplier bit is set.
                    if (r_x[0]) r_acc <= w_sum;
                    r_x <= r_x >> 1;
                    r_y <= r_y << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_val <= ext(r_x[0] ? w_sum : r_acc);
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    r_acc <= w_dfit ? w_sum : w_prem[W-1:0];
                    r_a   <= {r_a[W-2:0], w_dfit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_rem <= ext(w_dfit ? w_sum : w_prem[W-1:0]);
                        r_val <= ext({r_a[W-2:0], w_dfit});
                        r_state <= S_DONE;
                    end
                end
                S_SQRT: begin
                    // Trial subtract of res + bit, one root bit per pass.
                    if (w_carry) begin
                        r_a   <= w_sum;
                        r_res <= (r_res >> 1) | r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0] || r_bit[1]) begin
                        r_val <= ext(w_carry ? ((r_res >> 1) | r_bit) : (r_res >> 1));
                        r_state <= S_DONE;
                    end
                end
                S_PMUL: begin
                    // res *= (exp bit ? base : 1): r_y = res shifted, r_x = factor.
                    if (r_cnt == CW'(W - 1)) begin
                        r_res <= r_exp[0] ? (r_x[0] ? w_sum : r_acc) : r_res;
                        r_exp <= r_exp >> 1;
                        r_cnt <= '0;
                        if ((r_exp >> 1) == '0) begin
                            r_val <= ext(r_exp[0] ? (r_x[0] ? w_sum : r_acc) : r_res);
                            r_state <= S_DONE;
                        end else begin
                            r_x <= r_base; r_y <= r_base; r_acc <= '0;
                            r_state <= S_PSQ;
                        end
                    end else if (r_cnt == '0) begin
                        // First pass: load the product with res itself.
                        r_x <= r_x >> 1;
                        r_y <= r_res << 1;
                        r_acc <= r_x[0] ? r_res : '0;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        if (r_x[0]) r_acc <= w_sum;
                        r_x <= r_x >> 1;
                        r_y <= r_y << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_PSQ: begin
                    // base *= base.
                    if (r_cnt == CW'(W - 1)) begin
                        r_base <= r_x[0] ? w_sum : r_acc;
                        r_x <= r_exp[0] ? (r_x[0] ? w_sum : r_acc) : '0;
                        r_cnt <= '0;
                        r_acc <= '0;
                        r_state <= S_PMUL;
                    end else begin
                        if (r_x[0]) r_acc <= w_sum;
                        r_x <= r_x >> 1;
                        r_y <= r_y << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    // Divide by zero: dividend is still in r_a.
                    if (r_op == uia_pkg::OP_MOD) begin
                        r_val <= r_dz ? ext(r_a) : r_rem;
                    end else if (r_dz) begin
                        r_val <= ext({W{1'b1}});
                    end
                    if (r_op == uia_pkg::OP_DIV) begin
                        r_rem <= '0;
                    end else if (r_dz) begin
                        r_rem <= ext(r_a);
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/uia_checker.sv -----
// ---------------------------------------------------------------------------
// Unsigned integer ALU port checker
// Watches the ports of the top level over time.
// ---------------------------------------------------------------------------
`include "unsigned64_integer_alu_top_macros.svh"

module uia_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_value_out,
    input logic        o_truth_flag,
    input logic [1:0]  o_order_sign,
    input logic        o_divide_by_zero
);
    `UIA_ASSERT_IMPL(a_busy_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `UIA_ASSERT_NEXT(a_one_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `UIA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_value_out))
    `UIA_ASSERT_IMPL(a_sign_code, i_clk, i_rst_n, o_valid, o_order_sign != 2'b10)
    `UIA_ASSERT_IMPL(a_dz_alone, i_clk, i_rst_n, o_valid && o_divide_by_zero,
        !o_truth_flag && o_order_sign == 2'b00)
endmodule

bind unsigned64_integer_alu_top uia_checker u_uia_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_value_out(o_value_out),
    .o_truth_flag(o_truth_flag), .o_order_sign(o_order_sign),
    .o_divide_by_zero(o_divide_by_zero)
);
